@@ rtl/brc_pkg.sv @@
package brc_pkg;

    // Frame framing
    localparam int unsigned FRAME_OVERHEAD = 6;
    localparam logic [7:0]  CAN_BYTE       = 8'h18;

    // Register reset values
    localparam logic [15:0] MAX_FRAME_LEN_RST    = 16'd8192;
    localparam logic [7:0]  RETRY_LIMIT_RST      = 8'd10;
    localparam logic [7:0]  EOF_FLAG_MASK_RST    = 8'd4;
    localparam logic [7:0]  HEADER_FLAG_MASK_RST = 8'd2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_FRAME_LEN    = 2'd0,
        CFG_RETRY_LIMIT      = 2'd1,
        CFG_EOF_FLAG_MASK    = 2'd2,
        CFG_HEADER_FLAG_MASK = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_TIMEOUT = 2'd1,
        KIND_ABORT   = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REPLY_NONE   = 2'd0,
        REPLY_ACK    = 2'd1,
        REPLY_NAK    = 2'd2,
        REPLY_CANCEL = 2'd3
    } reply_t;

    typedef enum logic [2:0] {
        ST_RUNNING     = 3'd0,
        ST_DONE        = 3'd1,
        ST_REMOTE_CAN  = 3'd2,
        ST_RETRIES_OUT = 3'd3,
        ST_TOO_LONG    = 3'd4,
        ST_BAD_HEADER  = 3'd5,
        ST_LOCAL_ABORT = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_LEN_LO = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef struct packed {
        reply_t      reply;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        frame_done;
        logic        frame_good;
        logic [15:0] payload_length;
        logic        header_frame;
        logic        last_frame;
        status_t     status;
    } result_t;

endpackage

@@ rtl/block_receive_checker.sv @@
// Block receive checker: receive side of a JMODEM-style block transfer.
// Input channel (in_valid / in_stall, kind, rx_byte) carries one event per
// transaction: a received byte, a receive timeout, a local abort or a
// restart. Each input transaction yields exactly one result transaction on
// the output channel (out_valid / out_stall): the reply byte to send, an
// optional payload byte, the verdict on a frame that ended, and the run
// status.
// A result is registered in the result register, or in the skid register
// when the result register holds one that is not taken. Throughput: one
// transaction per cycle while in_stall is low; the frame state and the
// 16-bit running checksum are updated in the same cycle the event arrives.
// in_stall is purely registered (it rises once the skid entry holds a
// result), so the block takes one more event into the skid register while
// the sink stalls; a stall that goes on after that backs up into in_stall.
// Reset (rst_n low, asynchronous) returns the configuration registers to
// their defaults (max length 8192, 10 retries, end flag 0x04, header flag
// 0x02), clears frame state and empties the output registers. A restart
// event clears frame state but keeps configuration.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user
// must do so only while no transaction is in flight, which the block does not enforce.
module block_receive_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  reply,
    output logic        data_valid,
    output logic [7:0]  data_byte,
    output logic        frame_done,
    output logic        frame_good,
    output logic [15:0] payload_length,
    output logic        header_frame,
    output logic        last_frame,
    output logic [2:0]  status
);

    // Configuration registers
    logic [15:0] max_frame_len_reg;
    logic [7:0]  retry_limit_reg;
    logic [7:0]  eof_flag_mask_reg;
    logic [7:0]  header_flag_mask_reg;

    // Frame state
    brc_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]      frame_length_reg, frame_length_next;
    logic [15:0]      byte_count_reg, byte_count_next;
    logic [15:0]      running_sum_reg, running_sum_next;
    logic [15:0]      received_sum_reg, received_sum_next;
    logic [7:0]       frame_type_reg, frame_type_next;
    logic [7:0]       frame_number_reg, frame_number_next;
    logic [7:0]       expected_number_reg, expected_number_next;
    logic [7:0]       retries_left_reg, retries_left_next;
    brc_pkg::status_t run_status_reg, run_status_next;
    logic             header_seen_reg, header_seen_next;

    // Output buffer: result register and skid register
    brc_pkg::result_t res;
    brc_pkg::result_t out_reg;
    brc_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    logic        accept;
    logic        pop;
    logic        do_retry;
    logic [15:0] len_full;
    logic [15:0] sum_pos;
    logic        good;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign pop      = out_valid_reg && !out_stall;

    assign len_full = {rx_byte, frame_length_reg[7:0]};
    assign sum_pos  = frame_length_reg - 16'd2;
    // checksum high byte comes with the event that ends the frame
    assign good     = (running_sum_reg == {rx_byte, received_sum_reg[7:0]})
                   && (frame_number_reg == expected_number_reg);

    // Event processing
    always_comb
    begin
        phase_next           = phase_reg;
        frame_length_next    = frame_length_reg;
        byte_count_next      = byte_count_reg;
        running_sum_next     = running_sum_reg;
        received_sum_next    = received_sum_reg;
        frame_type_next      = frame_type_reg;
        frame_number_next    = frame_number_reg;
        expected_number_next = expected_number_reg;
        retries_left_next    = retries_left_reg;
        run_status_next      = run_status_reg;
        header_seen_next     = header_seen_reg;
        res                  = '0;
        res.reply            = brc_pkg::REPLY_NONE;
        do_retry             = 1'b0;

        if (brc_pkg::kind_t'(kind) == brc_pkg::KIND_RESTART)
        begin
            phase_next           = brc_pkg::PH_LEN_LO;
            frame_length_next    = '0;
            byte_count_next      = '0;
            running_sum_next     = '0;
            received_sum_next    = '0;
            frame_type_next      = '0;
            frame_number_next    = '0;
            expected_number_next = '0;
            retries_left_next    = retry_limit_reg;
            run_status_next      = brc_pkg::ST_RUNNING;
            header_seen_next     = 1'b0;
        end
        else if (run_status_reg == brc_pkg::ST_RUNNING)
        begin
            unique case (brc_pkg::kind_t'(kind))
                brc_pkg::KIND_BYTE:
                begin
                    unique case (phase_reg)
                        brc_pkg::PH_LEN_LO:
                        begin
                            frame_length_next = {8'd0, rx_byte};
                            running_sum_next  = {8'd0, rx_byte};
                            byte_count_next   = 16'd1;
                            phase_next        = brc_pkg::PH_LEN_HI;
                        end
                        brc_pkg::PH_LEN_HI:
                        begin
                            frame_length_next = len_full;
                            running_sum_next  = running_sum_reg + {8'd0, rx_byte};
                            byte_count_next   = 16'd2;
                            if (len_full > max_frame_len_reg)
                            begin
                                phase_next      = brc_pkg::PH_LEN_LO;
                                byte_count_next = '0;
                                run_status_next = brc_pkg::ST_TOO_LONG;
                                res.reply       = brc_pkg::REPLY_CANCEL;
                            end
                            else if (len_full < 16'(brc_pkg::FRAME_OVERHEAD))
                            begin
                                // short frame: judged bad at once
                                res.frame_done = 1'b1;
                                do_retry       = 1'b1;
                            end
                            else
                            begin
                                phase_next = brc_pkg::PH_BODY;
                            end
                        end
                        brc_pkg::PH_BODY:
                        begin
                            byte_count_next = byte_count_reg + 16'd1;
                            if (byte_count_reg < sum_pos)
                                running_sum_next = running_sum_reg + {8'd0, rx_byte};
                            if (byte_count_reg == 16'd2)
                                frame_type_next = rx_byte;
                            else if (byte_count_reg == 16'd3)
                                frame_number_next = rx_byte;
                            else if (byte_count_reg < sum_pos)
                            begin
                                res.data_valid = 1'b1;
                                res.data_byte  = rx_byte;
                            end
                            else if (byte_count_reg == sum_pos)
                                received_sum_next = {8'd0, rx_byte};
                            else
                            begin
                                // last checksum byte: judge the frame
                                received_sum_next  = {rx_byte, received_sum_reg[7:0]};
                                res.frame_done     = 1'b1;
                                res.frame_good     = good;
                                res.payload_length = frame_length_reg
                                                   - 16'(brc_pkg::FRAME_OVERHEAD);
                                phase_next         = brc_pkg::PH_LEN_LO;
                                byte_count_next    = '0;
                                if (!good)
                                    do_retry = 1'b1;
                                else if (!header_seen_reg)
                                begin
                                    if ((frame_type_reg & header_flag_mask_reg) != 8'd0)
                                    begin
                                        header_seen_next     = 1'b1;
                                        expected_number_next = expected_number_reg + 8'd1;
                                        retries_left_next    = retry_limit_reg;
                                        res.reply            = brc_pkg::REPLY_ACK;
                                        res.header_frame     = 1'b1;
                                    end
                                    else
                                    begin
                                        run_status_next = brc_pkg::ST_BAD_HEADER;
                                        res.reply       = brc_pkg::REPLY_CANCEL;
                                    end
                                end
                                else
                                begin
                                    expected_number_next = expected_number_reg + 8'd1;
                                    retries_left_next    = retry_limit_reg;
                                    res.reply            = brc_pkg::REPLY_ACK;
                                    if ((frame_type_reg & eof_flag_mask_reg) != 8'd0)
                                    begin
                                        res.last_frame  = 1'b1;
                                        run_status_next = brc_pkg::ST_DONE;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = brc_pkg::PH_LEN_LO;
                        end
                    endcase
                end
                brc_pkg::KIND_TIMEOUT:
                begin
                    if (phase_reg == brc_pkg::PH_BODY && byte_count_reg > 16'd2
                        && frame_type_reg == brc_pkg::CAN_BYTE)
                    begin
                        phase_next      = brc_pkg::PH_LEN_LO;
                        byte_count_next = '0;
                        run_status_next = brc_pkg::ST_REMOTE_CAN;
                        res.reply       = brc_pkg::REPLY_CANCEL;
                    end
                    else
                        do_retry = 1'b1;
                end
                default:
                begin
                    // local abort
                    phase_next      = brc_pkg::PH_LEN_LO;
                    byte_count_next = '0;
                    run_status_next = brc_pkg::ST_LOCAL_ABORT;
                    res.reply       = brc_pkg::REPLY_CANCEL;
                end
            endcase
        end

        // bad frame or timeout: drop the frame and spend a retry
        if (do_retry)
        begin
            phase_next      = brc_pkg::PH_LEN_LO;
            byte_count_next = '0;
            if (retries_left_reg <= 8'd1)
            begin
                retries_left_next = '0;
                run_status_next   = brc_pkg::ST_RETRIES_OUT;
                res.reply         = brc_pkg::REPLY_CANCEL;
            end
            else
            begin
                retries_left_next = retries_left_reg - 8'd1;
                res.reply         = brc_pkg::REPLY_NAK;
            end
        end

        res.status = run_status_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_len_reg    <= brc_pkg::MAX_FRAME_LEN_RST;
            retry_limit_reg      <= brc_pkg::RETRY_LIMIT_RST;
            eof_flag_mask_reg    <= brc_pkg::EOF_FLAG_MASK_RST;
            header_flag_mask_reg <= brc_pkg::HEADER_FLAG_MASK_RST;
        end
        else if (cfg_write)
        begin
            unique case (brc_pkg::cfg_index_t'(cfg_index))
                brc_pkg::CFG_MAX_FRAME_LEN:    max_frame_len_reg    <= cfg_data;
                brc_pkg::CFG_RETRY_LIMIT:      retry_limit_reg      <= cfg_data[7:0];
                brc_pkg::CFG_EOF_FLAG_MASK:    eof_flag_mask_reg    <= cfg_data[7:0];
                brc_pkg::CFG_HEADER_FLAG_MASK: header_flag_mask_reg <= cfg_data[7:0];
                default:                       max_frame_len_reg    <= max_frame_len_reg;
            endcase
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= brc_pkg::PH_LEN_LO;
            frame_length_reg    <= '0;
            byte_count_reg      <= '0;
            running_sum_reg     <= '0;
            received_sum_reg    <= '0;
            frame_type_reg      <= '0;
            frame_number_reg    <= '0;
            expected_number_reg <= '0;
            retries_left_reg    <= brc_pkg::RETRY_LIMIT_RST;
            run_status_reg      <= brc_pkg::ST_RUNNING;
            header_seen_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg           <= phase_next;
            frame_length_reg    <= frame_length_next;
            byte_count_reg      <= byte_count_next;
            running_sum_reg     <= running_sum_next;
            received_sum_reg    <= received_sum_next;
            frame_type_reg      <= frame_type_next;
            frame_number_reg    <= frame_number_next;
            expected_number_reg <= expected_number_next;
            retries_left_reg    <= retries_left_next;
            run_status_reg      <= run_status_next;
            header_seen_reg     <= header_seen_next;
        end
    end

    // Output buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reply          = out_reg.reply;
    assign data_valid     = out_reg.data_valid;
    assign data_byte      = out_reg.data_byte;
    assign frame_done     = out_reg.frame_done;
    assign frame_good     = out_reg.frame_good;
    assign payload_length = out_reg.payload_length;
    assign header_frame   = out_reg.header_frame;
    assign last_frame     = out_reg.last_frame;
    assign status         = out_reg.status;

endmodule
